// File: src/cicp_pkg.sv
`timescale 1ns / 1ps

package cicp_pkg;

    localparam int NUM_CHIPS = 2;
    localparam int LINE_W    = 8;
    localparam int LINE_IDX_W = 4;   // 0..7 a line, 8 for none

    localparam logic [LINE_IDX_W-1:0] NO_LINE = 4'd8;

    // function codes of an input item
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] FUNC_ACK    = 2'd3;

    // init sequence steps
    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_ICW2 = 2'd1;
    localparam logic [1:0] STEP_ICW3 = 2'd2;
    localparam logic [1:0] STEP_ICW4 = 2'd3;

    // command port decode
    localparam int ICW1_BIT  = 4;
    localparam int OCW3_BIT  = 3;
    localparam int OCW3_RR   = 1;
    localparam int OCW3_RIS  = 0;
    localparam int ICW1_LTIM = 3;
    localparam int ICW1_IC4  = 0;

    localparam logic [2:0] OCW2_NS_EOI   = 3'b001;
    localparam logic [2:0] OCW2_SPEC_EOI = 3'b011;

    localparam int          CASCADE_LINE = 2;
    localparam logic [7:0]  FLOAT_BUS    = 8'hFF;
    localparam logic [2:0]  SPURIOUS_LINE = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic        chip_sel;
        logic        port_a0;
        logic [7:0]  wdata;
        logic [15:0] irq_lines;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       int_out;
        logic [7:0] vector;
        logic       vector_valid;
    } result_t;

    typedef struct packed {
        logic [7:0] irr;
        logic [7:0] isr;
        logic [7:0] imr;
        logic [4:0] base;
        logic [1:0] init_step;
        logic       read_isr;
        logic       needs_icw4;
        logic       level_trig;
        logic [7:0] cascade;
        logic [7:0] prev_lines;
    } chip_state_t;

    function automatic logic [LINE_IDX_W-1:0] low_index(input logic [LINE_W-1:0] v);
        logic [LINE_IDX_W-1:0] idx;
        idx = NO_LINE;
        for (int i = LINE_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = LINE_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // winning line of a chip, NO_LINE when nothing beats the in-service level
    function automatic logic [LINE_IDX_W-1:0] winner(input chip_state_t s);
        logic [LINE_IDX_W-1:0] p;
        logic [LINE_IDX_W-1:0] q;
        p = low_index(s.irr & ~s.imr);
        q = low_index(s.isr);
        return (p < q) ? p : NO_LINE;
    endfunction

    function automatic chip_state_t latch_lines(input chip_state_t s,
                                                input logic [LINE_W-1:0] lines);
        chip_state_t r;
        r = s;
        if (s.level_trig) begin
            r.irr = lines;
        end
        else begin
            r.irr = (s.irr | (lines & ~s.prev_lines)) & lines;
        end
        r.prev_lines = lines;
        return r;
    endfunction

endpackage

// File: src/cascaded_interrupt_controller_pair.sv
`timescale 1ns / 1ps

// master/slave pair of 8259a-style interrupt controllers
//
// command channel: an item (bus write, bus read, request line sample or
// interrupt acknowledge) is taken at a rising edge with start high and busy
// low. busy is always low: one item per clock cycle is taken
// indefinitely.
// result channel: every item gives one result, shown on result for one
// cycle while done is high; the receiver has no way to stall it.
// the item is captured in an input register at the transfer edge, then one
// pass of priority encoding, init/ocw decode and request latching updates
// both chips' state and the result register on the following edge.
// throughput: one item per cycle, set by that single pass; each item sees
// the state left by the one before it.
// reset: both chips clear to zero (not initializing, edge triggered, irr
// read selected, base 0, no cascade). no result is pending after reset.
// the slave's interrupt output feeds master line 2; bit 2 of the sampled
// lines is ignored.
module cascaded_interrupt_controller_pair (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cicp_pkg::item_t item,
    output logic            done,
    output cicp_pkg::result_t result
);

    // input stage
    logic             stage_valid_reg;
    cicp_pkg::item_t  stage_reg;

    // per-chip state, index 0 master, 1 slave
    cicp_pkg::chip_state_t chip_reg  [cicp_pkg::NUM_CHIPS];
    cicp_pkg::chip_state_t chip_next [cicp_pkg::NUM_CHIPS];

    // result stage
    logic              done_reg;
    cicp_pkg::result_t result_reg;
    cicp_pkg::result_t result_next;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // one pass: bus op on the current state, then slave latch, then master latch
    always_comb
    begin
        cicp_pkg::chip_state_t      op  [cicp_pkg::NUM_CHIPS];
        cicp_pkg::chip_state_t      cur;
        logic [cicp_pkg::LINE_IDX_W-1:0] p_m;
        logic [cicp_pkg::LINE_IDX_W-1:0] p_s;
        logic [7:0]                 m_lines;
        logic [7:0]                 s_lines;
        logic                       s_int;
        logic [7:0]                 d;

        op[0] = chip_reg[0];
        op[1] = chip_reg[1];
        cur   = chip_reg[stage_reg.chip_sel];
        d     = stage_reg.wdata;
        p_m   = cicp_pkg::winner(chip_reg[0]);
        p_s   = cicp_pkg::winner(chip_reg[1]);

        result_next              = '0;

        case (stage_reg.func)
            cicp_pkg::FUNC_WRITE:
            begin
                if (!stage_reg.port_a0) begin
                    if (d[cicp_pkg::ICW1_BIT]) begin
                        // icw1 restarts the init sequence
                        cur.needs_icw4 = d[cicp_pkg::ICW1_IC4];
                        cur.level_trig = d[cicp_pkg::ICW1_LTIM];
                        cur.irr        = '0;
                        cur.isr        = '0;
                        cur.imr        = '0;
                        cur.read_isr   = 1'b0;
                        cur.init_step  = cicp_pkg::STEP_ICW2;
                    end
                    else if (d[cicp_pkg::OCW3_BIT]) begin
                        if (d[cicp_pkg::OCW3_RR]) begin
                            cur.read_isr = d[cicp_pkg::OCW3_RIS];
                        end
                    end
                    else if (d[7:5] == cicp_pkg::OCW2_NS_EOI) begin
                        // drop the highest-priority in-service bit
                        cur.isr = cur.isr & (cur.isr - 8'd1);
                    end
                    else if (d[7:5] == cicp_pkg::OCW2_SPEC_EOI) begin
                        cur.isr[d[2:0]] = 1'b0;
                    end
                end
                else begin
                    case (cur.init_step)
                        cicp_pkg::STEP_ICW2:
                        begin
                            cur.base      = d[7:3];
                            cur.init_step = cicp_pkg::STEP_ICW3;
                        end
                        cicp_pkg::STEP_ICW3:
                        begin
                            cur.cascade   = d;
                            cur.init_step = cur.needs_icw4 ? cicp_pkg::STEP_ICW4
                                                           : cicp_pkg::STEP_IDLE;
                        end
                        cicp_pkg::STEP_ICW4:
                        begin
                            cur.init_step = cicp_pkg::STEP_IDLE;
                        end
                        default:
                        begin
                            cur.imr = d;
                        end
                    endcase
                end
                op[stage_reg.chip_sel] = cur;
            end
            cicp_pkg::FUNC_READ:
            begin
                if (stage_reg.port_a0) begin
                    result_next.rdata = cur.imr;
                end
                else begin
                    result_next.rdata = cur.read_isr ? cur.isr : cur.irr;
                end
            end
            cicp_pkg::FUNC_ACK:
            begin
                result_next.vector_valid = 1'b1;
                if (p_m != cicp_pkg::NO_LINE && chip_reg[0].cascade[p_m[2:0]]) begin
                    op[0].isr[p_m[2:0]] = 1'b1;
                    op[0].irr[p_m[2:0]] = 1'b0;
                    if ({1'b0, chip_reg[1].cascade[2:0]} == p_m) begin
                        if (p_s == cicp_pkg::NO_LINE) begin
                            result_next.vector = {chip_reg[1].base,
                                                  cicp_pkg::SPURIOUS_LINE};
                        end
                        else begin
                            op[1].isr[p_s[2:0]] = 1'b1;
                            op[1].irr[p_s[2:0]] = 1'b0;
                            result_next.vector  = {chip_reg[1].base, p_s[2:0]};
                        end
                    end
                    else begin
                        // no slave answers on the cascade bus
                        result_next.vector = cicp_pkg::FLOAT_BUS;
                    end
                end
                else if (p_m == cicp_pkg::NO_LINE) begin
                    result_next.vector = {chip_reg[0].base, cicp_pkg::SPURIOUS_LINE};
                end
                else begin
                    op[0].isr[p_m[2:0]] = 1'b1;
                    op[0].irr[p_m[2:0]] = 1'b0;
                    result_next.vector  = {chip_reg[0].base, p_m[2:0]};
                end
            end
            default:
            begin
                // line sample: only the latching below acts
            end
        endcase

        // a sample item brings new levels, every other item re-evaluates old ones
        if (stage_reg.func == cicp_pkg::FUNC_SAMPLE) begin
            s_lines = stage_reg.irq_lines[15:8];
            m_lines = stage_reg.irq_lines[7:0];
        end
        else begin
            s_lines = chip_reg[1].prev_lines;
            m_lines = chip_reg[0].prev_lines;
        end

        chip_next[1] = cicp_pkg::latch_lines(op[1], s_lines);
        s_int        = (cicp_pkg::winner(chip_next[1]) != cicp_pkg::NO_LINE);
        m_lines[cicp_pkg::CASCADE_LINE] = s_int;
        chip_next[0] = cicp_pkg::latch_lines(op[0], m_lines);

        result_next.int_out = (cicp_pkg::winner(chip_next[0]) != cicp_pkg::NO_LINE);
    end

    // control and chip state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
            chip_reg[0]     <= '0;
            chip_reg[1]     <= '0;
        end
        else begin
            stage_valid_reg <= start && !busy;
            done_reg        <= stage_valid_reg;
            if (stage_valid_reg) begin
                chip_reg[0] <= chip_next[0];
                chip_reg[1] <= chip_next[1];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            stage_reg <= item;
        end
        if (stage_valid_reg) begin
            result_reg <= result_next;
        end
    end

    // int_out reports the master state the item left behind
    a_int_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.int_out ==
            (cicp_pkg::winner(chip_reg[0]) != cicp_pkg::NO_LINE))
        else $error("int_out disagrees with master state");

    // an acknowledge never returns read data
    a_ack_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.vector_valid |-> result.rdata == 8'd0)
        else $error("read data on acknowledge result");

    // a vector only comes with an acknowledge
    a_vector_only_ack: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.vector_valid |-> result.vector == 8'd0)
        else $error("vector without acknowledge");

    // every captured transfer raises done once it has passed the input register and then the result register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result strobe missing");

endmodule
